/* sv/cordic_sine_cosine_unit_defines.svh */
// ----------------------------------------------------------------------------
// CORDIC sine/cosine unit assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef CORDIC_SINE_COSINE_UNIT_DEFINES_SVH
`define CORDIC_SINE_COSINE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/cs_pkg.sv */
// ----------------------------------------------------------------------------
// CORDIC sine/cosine package
// Shared control type, fixed-point constants and elaboration-time helpers
// for the arctangent table.
// ----------------------------------------------------------------------------
package cs_pkg;

  localparam int COUNT_WIDTH = 6;
  localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = 6'd16;
  localparam int IO_WIDTH = 32;

  localparam logic [63:0] INV_GAIN_Q64   = 64'h9B74_EDA8_435E_5A68;
  localparam logic [63:0] QUARTER_PI_Q64 = 64'hC90F_DAA2_2168_C235;

  typedef struct packed {
    logic                   advance;
    logic [COUNT_WIDTH-1:0] count;
  } cs_ctrl_t;

  // floor(2^p / d) by restoring long division, d below 256
  function automatic logic [63:0] pow2_div(input int unsigned p, input int unsigned d);
    logic [63:0] num;
    logic [63:0] quo;
    logic [8:0]  rem;
    num = 64'd1 << p;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[7:0], num[i]};
      if (rem >= 9'(d)) begin
        rem = rem - 9'(d);
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-k) as unsigned Q0.64, odd power series for k above zero
  function automatic logic [63:0] atan_q64(input int unsigned k);
    logic [63:0] sum;
    int unsigned odd;
    int unsigned e;
    sum = '0;
    if (k == 0) begin
      return QUARTER_PI_Q64;
    end
    if (k >= 64) begin
      return 64'd0;
    end
    for (int m = 0; m < 32; m++) begin
      odd = 2 * m + 1;
      e = k * odd;
      if (e < 64) begin
        if (m[0]) begin
          sum = sum - pow2_div(64 - e, odd);
        end else begin
          sum = sum + pow2_div(64 - e, odd);
        end
      end
    end
    return sum;
  endfunction

  // round half up of q / 2^s, wrapping at 64 bits
  function automatic logic [63:0] round_shift(input logic [63:0] q, input int unsigned s);
    logic [63:0] t;
    t = q + (64'd1 << (s - 1));
    return t >> s;
  endfunction

endpackage

/* sv/cs_stage.sv */
// ----------------------------------------------------------------------------
// CORDIC micro-rotation stage
// One registered rotation step K, pass-through from the count on: by the sign
// of residual angle z, shift-add x, y, and subtract or add the table arctangent.
// ----------------------------------------------------------------------------
module cs_stage #(
  parameter int K = 0,
  parameter int W = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cs_pkg::cs_ctrl_t       ctrl,
  input  logic                   in_valid,
  input  logic signed [W-1:0]    in_x,
  input  logic signed [W-1:0]    in_y,
  input  logic signed [W-1:0]    in_z,
  output logic                   out_valid,
  output logic signed [W-1:0]    out_x,
  output logic signed [W-1:0]    out_y,
  output logic signed [W-1:0]    out_z
);
  import cs_pkg::*;

  localparam int          ROM_SHIFT = 67 - W;
  localparam logic [63:0] ATAN_WIDE = round_shift(atan_q64(K), ROM_SHIFT);
  localparam logic signed [W-1:0] ATAN = ATAN_WIDE[W-1:0];

  logic                active;
  logic signed [W-1:0] xs;
  logic signed [W-1:0] ys;
  logic signed [W-1:0] x_next;
  logic signed [W-1:0] y_next;
  logic signed [W-1:0] z_next;

  assign active = 7'(K) < {1'b0, ctrl.count};
  assign xs = in_x >>> K;
  assign ys = in_y >>> K;

  always_comb begin
    x_next = in_x;
    y_next = in_y;
    z_next = in_z;
    if (active) begin
      if (!in_z[W-1]) begin
        x_next = in_x - ys;
        y_next = in_y + xs;
        z_next = in_z - ATAN;
      end else begin
        x_next = in_x + ys;
        y_next = in_y - xs;
        z_next = in_z + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      out_x <= x_next;
      out_y <= y_next;
      out_z <= z_next;
    end
  end

endmodule

/* sv/cordic_sine_cosine_unit.sv */
// ----------------------------------------------------------------------------
// CORDIC sine/cosine unit
// Circular rotation-mode CORDIC: Q3.29 angle in, Q2.30 cosine and sine out.
// ----------------------------------------------------------------------------
// Accepts one angle per cycle while the pipeline is not held and returns
// its cosine and sine; the pipeline holds one register stage per micro-rotation,
// and the last stage is the output register. Stages at or beyond the
// configured iteration_count pass data through unchanged, so latency does
// not depend on the count. A stalled result holds the whole pipeline, and
// angle_stall follows it. Angles are not range-reduced: results are valid
// for magnitudes up to about 1.74 rad. Write iteration_count only while no
// angle is in flight.
`include "cordic_sine_cosine_unit_defines.svh"

module cordic_sine_cosine_unit #(
  parameter int MAX_ITERATIONS = 32,
  parameter int DATA_WIDTH     = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cs_pkg::COUNT_WIDTH-1:0]  cfg_data,
  input  logic                            angle_valid,
  output logic                            angle_stall,
  input  logic signed [cs_pkg::IO_WIDTH-1:0] angle,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic signed [cs_pkg::IO_WIDTH-1:0] cosine,
  output logic signed [cs_pkg::IO_WIDTH-1:0] sine
);
  import cs_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam int GAIN_SHIFT = 66 - W;
  localparam logic [63:0] INV_GAIN_WIDE = round_shift(INV_GAIN_Q64, GAIN_SHIFT);
  localparam logic signed [W-1:0] INV_GAIN = INV_GAIN_WIDE[W-1:0];

  logic [COUNT_WIDTH-1:0] iteration_count;
  cs_ctrl_t               ctrl;

  logic [MAX_ITERATIONS-1:0] stage_valid;
  logic signed [W-1:0] stage_x [MAX_ITERATIONS+1];
  logic signed [W-1:0] stage_y [MAX_ITERATIONS+1];
  logic signed [W-1:0] stage_z [MAX_ITERATIONS+1];
  logic [MAX_ITERATIONS:0] valid_chain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_count <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      iteration_count <= cfg_data;
    end
  end

  assign ctrl.advance = !(stage_valid[MAX_ITERATIONS-1] && result_stall);
  assign ctrl.count   = iteration_count;
  assign angle_stall  = !ctrl.advance;

  assign valid_chain[0] = angle_valid;
  assign stage_x[0] = INV_GAIN;
  assign stage_y[0] = '0;

  generate
    if (W >= IO_WIDTH) begin : g_in_wide
      assign stage_z[0] = W'(angle) <<< (W - IO_WIDTH);
    end else begin : g_in_narrow
      assign stage_z[0] = W'(angle >>> (IO_WIDTH - W));
    end
  endgenerate

  generate
    for (genvar k = 0; k < MAX_ITERATIONS; k++) begin : g_stage
      cs_stage #(
        .K (k),
        .W (W)
      ) u_stage (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .in_valid  (valid_chain[k]),
        .in_x      (stage_x[k]),
        .in_y      (stage_y[k]),
        .in_z      (stage_z[k]),
        .out_valid (valid_chain[k+1]),
        .out_x     (stage_x[k+1]),
        .out_y     (stage_y[k+1]),
        .out_z     (stage_z[k+1])
      );
    end
  endgenerate

  assign stage_valid  = valid_chain[MAX_ITERATIONS:1];
  assign result_valid = stage_valid[MAX_ITERATIONS-1];

  generate
    if (W > IO_WIDTH) begin : g_out_wide
      assign cosine = IO_WIDTH'(stage_x[MAX_ITERATIONS] >>> (W - IO_WIDTH));
      assign sine   = IO_WIDTH'(stage_y[MAX_ITERATIONS] >>> (W - IO_WIDTH));
    end else begin : g_out_narrow
      assign cosine = IO_WIDTH'(stage_x[MAX_ITERATIONS]) <<< (IO_WIDTH - W);
      assign sine   = IO_WIDTH'(stage_y[MAX_ITERATIONS]) <<< (IO_WIDTH - W);
    end
  endgenerate

  `CSU_ASSERT_NEXT(a_hold_freezes, !ctrl.advance, $stable(stage_valid), "pipeline moved while held")
  `CSU_ASSERT_NEXT(a_accept_enters, angle_valid && !angle_stall, stage_valid[0], "accepted angle lost at entry")
  `CSU_ASSERT_NEXT(a_no_invent, ctrl.advance && !angle_valid, $countones(stage_valid) <= $past($countones(stage_valid)), "item appeared without transfer")

endmodule

/* tb/cordic_sine_cosine_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CORDIC sine/cosine unit testbench
// Streams Q3.29 angles through the unit under several iteration counts,
// predicts each cosine/sine pair with a bit-exact rotation-mode model and
// compares every returned pair in order. Both sides idle and stall at random;
// one stretch runs without gaps and the result side holds off for a long
// stretch so that the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
module cordic_sine_cosine_unit_tb;
  import cs_pkg::*;

  localparam int STAGES         = 32;
  localparam int PHASES         = 10;
  localparam int PER_PHASE      = 135;
  localparam int ANGLE_LIMIT    = 934155000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  class sincos_scoreboard;
    logic [COUNT_WIDTH-1:0] turns;
    logic signed [31:0]     arctan_tbl [STAGES];
    logic signed [31:0]     unit_x;
    logic signed [31:0]     cos_due [$];
    logic signed [31:0]     sin_due [$];
    int                     angles_in;
    int                     results_out;
    int                     mismatches;

    function new();
      logic [63:0] wide;
      turns       = COUNT_RESET;
      angles_in   = 0;
      results_out = 0;
      mismatches  = 0;
      wide        = (INV_GAIN_Q64 + (64'd1 << 33)) >> 34;
      unit_x      = wide[31:0];
      for (int k = 0; k < STAGES; k++) begin
        wide          = (arctan_frac(k) + (64'd1 << 34)) >> 35;
        arctan_tbl[k] = wide[31:0];
      end
    endfunction

    // atan(2^-k) as unsigned Q0.64
    function logic [63:0] arctan_frac(int unsigned k);
      logic [63:0] acc;
      int unsigned odd;
      acc = '0;
      if (k == 0) return QUARTER_PI_Q64;
      for (int unsigned m = 0; k * (2 * m + 1) < 64; m++) begin
        odd = 2 * m + 1;
        if (m % 2) acc = acc - (64'd1 << (64 - k * odd)) / 64'(odd);
        else       acc = acc + (64'd1 << (64 - k * odd)) / 64'(odd);
      end
      return acc;
    endfunction

    function void note_angle(logic signed [31:0] a);
      logic signed [31:0] x, y, z, xs, ys;
      int n;
      x = unit_x;
      y = '0;
      z = a;
      n = (turns > STAGES) ? STAGES : int'(turns);
      for (int k = 0; k < n; k++) begin
        xs = x >>> k;
        ys = y >>> k;
        if (z[31]) begin
          x = x + ys;
          y = y - xs;
          z = z + arctan_tbl[k];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - arctan_tbl[k];
        end
      end
      cos_due.push_back(x);
      sin_due.push_back(y);
      angles_in++;
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH @%0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic signed [31:0] c, logic signed [31:0] s);
      logic signed [31:0] c_exp, s_exp;
      results_out++;
      if (cos_due.size() == 0) begin
        report_mismatch($sformatf("result cos=%0d sin=%0d with no angle pending", c, s));
        return;
      end
      c_exp = cos_due.pop_front();
      s_exp = sin_due.pop_front();
      if (c !== c_exp)
        report_mismatch($sformatf("cosine %0d, want %0d (result %0d)", c, c_exp, results_out));
      if (s !== s_exp)
        report_mismatch($sformatf("sine %0d, want %0d (result %0d)", s, s_exp, results_out));
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [COUNT_WIDTH-1:0] cfg_data;
  logic                   angle_valid;
  logic                   angle_stall;
  logic signed [31:0]     angle;
  logic                   result_valid;
  logic                   result_stall;
  logic signed [31:0]     cosine;
  logic signed [31:0]     sine;

  sincos_scoreboard board;
  int idle_pct;
  int stall_pct;
  int holdoffs_asked;
  int quiet_cycles;
  int counts_used;

  cordic_sine_cosine_unit #(
    .MAX_ITERATIONS(STAGES),
    .DATA_WIDTH(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .angle_valid(angle_valid),
    .angle_stall(angle_stall),
    .angle(angle),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .cosine(cosine),
    .sine(sine)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic signed [31:0] pick_angle();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return int'($urandom_range(0, 2 * ANGLE_LIMIT)) - ANGLE_LIMIT;
    if (r < 90) return $urandom;
    return int'($urandom_range(0, 2047)) - 1024;
  endfunction

  task automatic send_angle(input logic signed [31:0] a);
    if ($urandom_range(99) < idle_pct) begin
      angle_valid <= 1'b0;
      @(posedge clk);
    end
    angle_valid <= 1'b1;
    angle       <= a;
    do @(posedge clk); while (angle_stall);
    board.note_angle(a);
  endtask

  task automatic wait_drained();
    angle_valid <= 1'b0;
    while (board.cos_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_count(input logic [COUNT_WIDTH-1:0] n);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.turns = n;
    counts_used++;
  endtask

  // result side: random stalls, long hold-off on request
  initial begin
    int hold_left;
    int holdoffs_served;
    hold_left       = 0;
    holdoffs_served = 0;
    result_stall    = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) board.check_result(cosine, sine);
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (holdoffs_served != holdoffs_asked) begin
        holdoffs_served++;
        hold_left = HOLDOFF_CYCLES;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (angle_valid && !angle_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic signed [31:0]     edge_angles [18];
    logic [COUNT_WIDTH-1:0] count_plan [PHASES];
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    angle_valid    = 1'b0;
    angle          = '0;
    idle_pct       = 15;
    stall_pct      = 15;
    holdoffs_asked = 0;
    quiet_cycles   = 0;
    counts_used    = 1;
    board          = new();
    edge_angles = '{32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                    32'sd421657428, -32'sd421657428, 32'sd843314857, -32'sd843314857,
                    32'sd934155000, -32'sd934155000, 32'sd536870912, -32'sd536870912,
                    32'sd1686629713, -32'sd1686629713, 32'sh5555_5555, 32'shAAAA_AAAA,
                    32'sh3FFF_FFFF};
    count_plan = '{COUNT_RESET, 6'd32, 6'd0, 6'd63, 6'd1, 6'd33, 6'd2, 6'd31,
                   6'($urandom_range(3, 30)), 6'($urandom_range(3, 30))};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        write_count(count_plan[p]);
      end
      idle_pct  <= (p == 1) ? 0 : 15;
      stall_pct <= (p == 1) ? 0 : 15;
      if (p == 4 || p == 8) holdoffs_asked <= holdoffs_asked + 1;
      if (p == 0) foreach (edge_angles[i]) send_angle(edge_angles[i]);
      repeat (PER_PHASE) send_angle(pick_angle());
    end
    wait_drained();
    repeat (STAGES + 8) @(posedge clk);
    if (board.cos_due.size() != 0)
      board.report_mismatch($sformatf("%0d results never arrived", board.cos_due.size()));
    $display("run: %0d angles in, %0d results checked, %0d iteration counts",
             board.angles_in, board.results_out, counts_used);
    $display("run: counts 0, 1, 32 and above maximum, out-of-range angles, %0d mismatches",
             board.mismatches);
    if (board.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
